@@ sv/hall_encoder_commutation_top_defines.svh @@
// ----------------------------------------------------------------------------
// hall encoder commutation assertion macros
// shared property shapes for the checks at the end of the top level
// ----------------------------------------------------------------------------
`ifndef HALL_ENCODER_COMMUTATION_TOP_DEFINES_SVH
`define HALL_ENCODER_COMMUTATION_TOP_DEFINES_SVH

// same-cycle implication, disabled in reset
`define HEC_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled in reset
`define HEC_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ sv/hec_pkg.sv @@
// ----------------------------------------------------------------------------
// hec_pkg
// shared types and codes of the hall encoder commutation block
// ----------------------------------------------------------------------------
package hec_pkg;

    // divider datapath widths
    localparam int DIV_NW = 48;
    localparam int DIV_DW = 40;
    localparam int DIV_CW = 6;

    typedef struct packed {
        logic              start;
        logic [DIV_CW-1:0] nbits;
        logic [DIV_NW-1:0] num;
        logic [DIV_DW-1:0] den;
    } t_div_req;

    typedef struct packed {
        logic              done;
        logic [DIV_NW-1:0] quot;
        logic [DIV_DW-1:0] rem;
    } t_div_rsp;

    // configuration register indexes
    localparam logic [2:0] REG_COMM_MODE   = 3'd0;
    localparam logic [2:0] REG_HALL_OFFSET = 3'd1;
    localparam logic [2:0] REG_CPR         = 3'd2;
    localparam logic [2:0] REG_POLE_PAIRS  = 3'd3;
    localparam logic [2:0] REG_CNT_TO_ANG  = 3'd4;
    localparam logic [2:0] REG_MAX_STEP    = 3'd5;
    localparam logic [2:0] REG_FAULT_EN    = 3'd6;

    // commutation modes
    localparam logic [2:0] MODE_OPEN    = 3'd0;
    localparam logic [2:0] MODE_HALL    = 3'd1;
    localparam logic [2:0] MODE_ENC     = 3'd2;
    localparam logic [2:0] MODE_ENC_RST = 3'd3;

    // hall status codes
    localparam logic [1:0] HS_NONE = 2'd0;
    localparam logic [1:0] HS_EDGE = 2'd1;
    localparam logic [1:0] HS_ERR  = 2'd2;

    // fault codes
    localparam logic [1:0] FC_NONE = 2'd0;
    localparam logic [1:0] FC_KEY  = 2'd1;
    localparam logic [1:0] FC_JUMP = 2'd2;
    localparam logic [1:0] FC_DEV  = 2'd3;

    localparam logic [2:0] BAD_SECTOR = 3'd7;

    function automatic logic [2:0] sector_of_key(input logic [2:0] key);
        logic [2:0] s;
        case (key)
            3'd1:    s = 3'd0;
            3'd2:    s = 3'd2;
            3'd3:    s = 3'd1;
            3'd4:    s = 3'd4;
            3'd5:    s = 3'd5;
            3'd6:    s = 3'd3;
            default: s = BAD_SECTOR;
        endcase
        return s;
    endfunction

endpackage

@@ sv/hec_if.sv @@
// ----------------------------------------------------------------------------
// hec_if
// item channels of the hall encoder commutation block
// ----------------------------------------------------------------------------
interface hec_in_if;
    logic               valid;
    logic               ready;
    logic [2:0]         hall_bits;
    logic signed [31:0] encoder_pos;
    logic [31:0]        edge_time;

    modport source (output valid, hall_bits, encoder_pos, edge_time, input ready);
    modport sink (input valid, hall_bits, encoder_pos, edge_time, output ready);
endinterface

interface hec_out_if;
    logic               valid;
    logic               ready;
    logic               ret_error;
    logic [1:0]         hall_status;
    logic [1:0]         fault_code;
    logic               fault_fatal;
    logic [15:0]        comm_angle;
    logic [15:0]        hall_angle_out;
    logic signed [25:0] hall_speed;
    logic [15:0]        status_word;
    logic [15:0]        hall_word;

    modport source (output valid, ret_error, hall_status, fault_code, fault_fatal,
                    comm_angle, hall_angle_out, hall_speed, status_word, hall_word,
                    input ready);
    modport sink (input valid, ret_error, hall_status, fault_code, fault_fatal,
                  comm_angle, hall_angle_out, hall_speed, status_word, hall_word,
                  output ready);
endinterface

@@ sv/hec_div.sv @@
// ----------------------------------------------------------------------------
// hec_div
// shared restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module hec_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  hec_pkg::t_div_req i_req,
    output hec_pkg::t_div_rsp o_rsp
);
    import hec_pkg::*;

    logic              r_busy;
    logic              r_done;
    logic [DIV_CW-1:0] r_cnt;
    logic [DIV_NW-1:0] r_q;
    logic [DIV_DW-1:0] r_r;
    logic [DIV_DW-1:0] r_d;

    logic [DIV_DW:0]   w_part;
    logic [DIV_DW+1:0] w_diff;
    logic              w_ge;

    // numerator arrives left aligned, so the top bit is always the next one
    assign w_part = {r_r, r_q[DIV_NW-1]};
    assign w_diff = {1'b0, w_part} - {2'b00, r_d};
    assign w_ge   = !w_diff[DIV_DW+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && !i_req.start && (r_cnt == DIV_CW'(1));
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_req.nbits;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == DIV_CW'(1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_q <= i_req.num;
            r_r <= '0;
            r_d <= i_req.den;
        end else if (r_busy) begin
            r_q <= {r_q[DIV_NW-2:0], w_ge};
            r_r <= w_ge ? w_diff[DIV_DW-1:0] : w_part[DIV_DW-1:0];
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_q;
    assign o_rsp.rem  = r_r;

endmodule

@@ sv/hall_encoder_commutation_top.sv @@
// ----------------------------------------------------------------------------
// hall_encoder_commutation_top
// hall sector decode, edge speed, encoder wrap and alignment, rate limited
// commutation angle
// ----------------------------------------------------------------------------
//  channel | dir | handshake          | payload
//  i_in    | in  | valid/ready        | hall_bits, encoder_pos, edge_time
//  o_out   | out | valid/ready        | errors, angles, speed, status words
//  i_cfg_* | in  | write enable only  | register index and 32-bit data
//
//  an item is taken only in idle, and the next one only after the result
//  commits; most of the time goes to the shared divider: 34 steps for the
//  encoder wrap, 25 for the hall count and 48 for the speed quotient when
//  a hall edge needs a speed figure, one bit per cycle
//  reset is synchronous, active low, and loads the register defaults
//  a finished result sits in the output register; the next item may be
//  taken meanwhile and only its last step waits for the output to drain
// ----------------------------------------------------------------------------
module hall_encoder_commutation_top #(
    parameter int CLOCK_HZ     = 200000000,
    parameter int ANGLE_BITS   = 16,
    parameter int ENCODER_BITS = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    hec_in_if.sink      i_in,
    hec_out_if.source   o_out,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_data
);
    import hec_pkg::*;

    `include "hall_encoder_commutation_top_defines.svh"

    localparam int AB    = ANGLE_BITS;
    localparam int EB    = ENCODER_BITS;
    localparam int SH_DN = (AB > 16) ? AB - 16 : 0;
    localparam int SH_UP = (AB < 16) ? 16 - AB : 0;
    localparam int SW    = 34;   // wrapped count plus signed encoder step

    localparam logic [AB-1:0] HALF_SECTOR = AB'(((64'd1 << AB) + 64'd6) / 64'd12);
    localparam logic [AB-1:0] SA0 = AB'(((64'd0 << AB) + 64'd3) / 64'd6);
    localparam logic [AB-1:0] SA1 = AB'(((64'd1 << AB) + 64'd3) / 64'd6);
    localparam logic [AB-1:0] SA2 = AB'(((64'd2 << AB) + 64'd3) / 64'd6);
    localparam logic [AB-1:0] SA3 = AB'(((64'd3 << AB) + 64'd3) / 64'd6);
    localparam logic [AB-1:0] SA4 = AB'(((64'd4 << AB) + 64'd3) / 64'd6);
    localparam logic [AB-1:0] SA5 = AB'(((64'd5 << AB) + 64'd3) / 64'd6);
    localparam logic [31:0] DT_MAX = 32'(CLOCK_HZ / 20);
    localparam logic [31:0] MIN_DT = 32'(10 * (CLOCK_HZ / 1000000));
    localparam logic [DIV_NW-1:0] NUM2 = DIV_NW'(64'(CLOCK_HZ) * 64'd2048);
    localparam logic [AB-1:0] DEV8 = AB'(64'd1 << (AB - 3));
    localparam logic [39:0] DEV100 = 40'(64'd12 << AB);

    typedef enum logic [13:0] {
        S_IDLE  = 14'b00000000000001,
        S_HALL  = 14'b00000000000010,
        S_MODST = 14'b00000000000100,
        S_MODW  = 14'b00000000001000,
        S_E4ST  = 14'b00000000010000,
        S_E4W   = 14'b00000000100000,
        S_DENM  = 14'b00000001000000,
        S_SPST  = 14'b00000010000000,
        S_SPW   = 14'b00000100000000,
        S_EAH   = 14'b00001000000000,
        S_EAE   = 14'b00010000000000,
        S_MODE  = 14'b00100000000000,
        S_EAF   = 14'b01000000000000,
        S_LIM   = 14'b10000000000000
    } t_state;

    function automatic logic [AB-1:0] from16(input logic [15:0] x);
        logic [47:0] t;
        t = (48'(x) << SH_DN) >> SH_UP;
        return t[AB-1:0];
    endfunction

    function automatic logic [15:0] to16(input logic [AB-1:0] a);
        logic [47:0] t;
        t = (48'(a) << SH_UP) >> SH_DN;
        return t[15:0];
    endfunction

    function automatic logic [AB-1:0] sect_angle(input logic [2:0] s);
        logic [AB-1:0] a;
        case (s)
            3'd0:    a = SA0;
            3'd1:    a = SA1;
            3'd2:    a = SA2;
            3'd3:    a = SA3;
            3'd4:    a = SA4;
            3'd5:    a = SA5;
            default: a = '0;
        endcase
        return a;
    endfunction

    // magnitude of the wrapped angle difference
    function automatic logic [AB-1:0] adiff(input logic [AB-1:0] a, input logic [AB-1:0] b);
        logic [AB-1:0] d;
        d = a - b;
        return d[AB-1] ? AB'(-d) : d;
    endfunction

    // configuration registers
    logic [2:0]  r_comm_mode;
    logic [15:0] r_hall_offset;
    logic [24:0] r_cpr;
    logic [5:0]  r_pole_pairs;
    logic [31:0] r_cnt_to_ang;
    logic [15:0] r_max_step;
    logic        r_fault_en;

    // tracking state
    t_state             r_state;
    logic [2:0]         r_sector;
    logic [1:0]         r_hall_fault;
    logic               r_started;
    logic [2:0]         r_prev_key;
    logic [2:0]         r_prev2_key;
    logic [AB-1:0]      r_hall_angle;
    logic [31:0]        r_last_edge;
    logic [EB-1:0]      r_last_enc;
    logic [24:0]        r_wrapped;
    logic [AB-1:0]      r_angle_now;
    logic               r_aligned;
    logic [15:0]        r_status_hold;
    logic signed [25:0] r_speed;

    // per item working registers
    logic [2:0]          r_key;
    logic [EB-1:0]       r_enc_in;
    logic [31:0]         r_edge;
    logic [1:0]          r_stat;
    logic                r_spd_go;
    logic                r_dir_fwd;
    logic [31:0]         r_t;
    logic signed [SW-1:0] r_s;
    logic [24:0]         r_enc;
    logic [24:0]         r_e4h;
    logic [24:0]         r_encf;
    logic [AB-1:0]       r_ah;
    logic [AB-1:0]       r_ae;
    logic                r_err;
    logic                r_fatal;
    logic [1:0]          r_fcode;
    logic                r_mode_ok;
    logic [63:0]         r_prod;

    // output register
    logic               r_out_valid;
    logic               r_o_err;
    logic [1:0]         r_o_stat;
    logic [1:0]         r_o_fcode;
    logic               r_o_fatal;
    logic [15:0]        r_o_comm;
    logic [15:0]        r_o_hall;
    logic [25:0]        r_o_speed;
    logic [15:0]        r_o_status;
    logic [15:0]        r_o_hword;

    t_div_req w_div_req;
    t_div_rsp w_div_rsp;

    logic [24:0]    w_cpr_eff;
    logic [5:0]     w_pp_eff;
    logic           w_accept;
    logic           w_commit;
    logic [31:0]    w_mul_a;
    logic [31:0]    w_mul_b;
    logic [AB-1:0]  w_prod_ang;

    assign w_cpr_eff  = (r_cpr == '0) ? 25'd1 : r_cpr;
    assign w_pp_eff   = (r_pole_pairs == '0) ? 6'd1 : r_pole_pairs;
    assign w_accept   = i_in.valid && i_in.ready;
    assign w_commit   = (r_state == S_LIM) && (!r_out_valid || o_out.ready);
    assign w_prod_ang = r_prod[32-AB +: AB];   // count times turns per count

    assign i_in.ready = (r_state == S_IDLE);

    // ------------------------------------------------------------------
    // hall decode of the current key against the held sector
    // ------------------------------------------------------------------
    logic [2:0]  w_val;
    logic [2:0]  w_step;
    logic [31:0] w_dt;
    logic        w_fast;

    assign w_val = sector_of_key(r_key);
    always_comb begin
        if (r_sector > 3'd5) begin
            w_step = 3'd3;
        end else if (w_val >= r_sector) begin
            w_step = w_val - r_sector;
        end else begin
            w_step = 3'(4'(w_val) + 4'd6 - 4'(r_sector));
        end
    end
    assign w_dt   = r_edge - r_last_edge;
    assign w_fast = !($signed(w_dt) > $signed(DT_MAX)) && (r_key != r_prev2_key);

    // ------------------------------------------------------------------
    // encoder step, wrapped sum and its remainder fixup
    // ------------------------------------------------------------------
    logic [EB-1:0]       w_du;
    logic signed [SW-1:0] w_s;
    logic [SW-1:0]       w_s_abs;
    logic [24:0]         w_rem;
    logic [24:0]         w_enc_wrap;

    assign w_du    = r_enc_in - r_last_enc;
    assign w_s     = $signed(SW'(r_wrapped)) + $signed({{(SW-EB){w_du[EB-1]}}, w_du});
    assign w_s_abs = r_s[SW-1] ? SW'(-r_s) : SW'(r_s);
    assign w_rem   = w_div_rsp.rem[24:0];
    assign w_enc_wrap = (r_s[SW-1] && (w_rem != '0)) ? (w_cpr_eff - w_rem) : w_rem;

    // ------------------------------------------------------------------
    // mode logic on the encoder count, the hall count and their angles
    // ------------------------------------------------------------------
    logic [AB-1:0] w_dev;
    logic          w_dev12;
    logic          w_dev8;
    logic [24:0]   n_encf;
    logic          n_aligned;
    logic          n_err;
    logic          n_fatal;
    logic [1:0]    n_fcode;
    logic          n_mode_ok;

    assign w_dev   = adiff(r_ah, r_ae);
    assign w_dev12 = (40'(w_dev) * 40'd100) > DEV100;
    assign w_dev8  = w_dev > DEV8;

    always_comb begin
        n_encf    = r_enc;
        n_aligned = r_aligned;
        n_err     = 1'b0;
        n_fatal   = 1'b0;
        n_fcode   = r_hall_fault;
        n_mode_ok = 1'b1;
        case (r_comm_mode)
            MODE_OPEN: n_mode_ok = 1'b1;
            MODE_HALL: begin
                if (r_hall_fault == FC_NONE) begin
                    n_encf = r_e4h;
                end else begin
                    n_fatal = 1'b1;
                    n_err   = 1'b1;
                end
            end
            MODE_ENC: begin
                if (!r_aligned) begin
                    if (r_hall_fault == FC_NONE) begin
                        if (r_stat == HS_EDGE) begin
                            n_encf    = r_e4h;
                            n_aligned = 1'b1;
                        end
                    end else begin
                        n_fatal = 1'b1;
                        n_err   = 1'b1;
                    end
                end else if (w_dev12) begin
                    n_fcode = FC_DEV;
                    n_fatal = 1'b1;
                end
            end
            MODE_ENC_RST: begin
                if (r_hall_fault == FC_NONE) begin
                    if (r_stat == HS_EDGE) begin
                        n_aligned = 1'b1;
                        n_encf    = r_e4h;
                    end else begin
                        if (w_dev8) begin
                            n_aligned = 1'b0;
                        end
                        if (!(r_aligned && !w_dev8)) begin
                            n_encf = r_e4h;
                        end
                    end
                end else if (!r_aligned) begin
                    n_fatal = 1'b1;
                    n_err   = 1'b1;
                end
            end
            default: begin
                n_mode_ok = 1'b0;
                n_err     = 1'b1;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // shared multiplier operand select, product registered every cycle
    // ------------------------------------------------------------------
    always_comb begin
        w_mul_a = '0;
        w_mul_b = r_cnt_to_ang;
        case (r_state)
            S_MODW, S_E4ST: begin
                w_mul_a = 32'(r_hall_angle);
                w_mul_b = 32'(w_cpr_eff);
            end
            S_DENM: begin
                w_mul_a = 32'(w_pp_eff) * 32'd6;
                w_mul_b = r_t;
            end
            S_EAH:   w_mul_a = 32'(r_e4h);
            S_EAE:   w_mul_a = 32'(r_enc);
            // final count angle must be ready on the first cycle of S_LIM
            S_EAF:   w_mul_a = 32'(n_encf);
            S_LIM:   w_mul_a = 32'(r_encf);
            default: w_mul_a = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_prod <= 64'(w_mul_a) * 64'(w_mul_b);
    end

    // ------------------------------------------------------------------
    // divider requests
    // ------------------------------------------------------------------
    always_comb begin
        w_div_req       = '0;
        w_div_req.start = 1'b0;
        case (r_state)
            S_MODST: begin
                w_div_req.start = 1'b1;
                w_div_req.nbits = DIV_CW'(SW);
                w_div_req.num   = {w_s_abs, (DIV_NW-SW)'(0)};
                w_div_req.den   = DIV_DW'(w_cpr_eff);
            end
            S_E4ST: begin
                w_div_req.start = 1'b1;
                w_div_req.nbits = DIV_CW'(25);
                w_div_req.num   = {r_prod[AB +: 25], (DIV_NW-25)'(0)};
                w_div_req.den   = DIV_DW'(w_pp_eff);
            end
            S_SPST: begin
                w_div_req.start = 1'b1;
                w_div_req.nbits = DIV_CW'(DIV_NW);
                w_div_req.num   = NUM2 + DIV_NW'(r_prod[DIV_DW-2:0]);
                w_div_req.den   = {r_prod[DIV_DW-2:0], 1'b0};
            end
            default: w_div_req.start = 1'b0;
        endcase
    end

    hec_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_rsp   (w_div_rsp)
    );

    // ------------------------------------------------------------------
    // rate limit toward the encoder angle
    // ------------------------------------------------------------------
    logic [AB-1:0]       w_d;
    logic signed [AB+1:0] w_ds;
    logic signed [AB+1:0] w_lim;
    logic signed [AB+1:0] w_dc;
    logic [AB-1:0]       n_angle_now;
    logic [15:0]         n_status;
    logic [15:0]         w_hword;

    assign w_d   = w_prod_ang - r_angle_now;
    assign w_ds  = $signed({{2{w_d[AB-1]}}, w_d});
    assign w_lim = $signed({2'b00, from16(r_max_step)});
    always_comb begin
        if (w_ds > w_lim) begin
            w_dc = w_lim;
        end else if (w_ds < -w_lim) begin
            w_dc = -w_lim;
        end else begin
            w_dc = w_ds;
        end
    end
    assign n_angle_now = (r_mode_ok && (r_comm_mode != MODE_OPEN))
                       ? r_angle_now + w_dc[AB-1:0] : r_angle_now;
    assign n_status = r_mode_ok
                    ? {r_stat == HS_EDGE, r_hall_fault != FC_NONE, r_err, r_aligned,
                       2'b00, n_angle_now[AB-1 -: 10]}
                    : r_status_hold;
    assign w_hword = {r_hall_angle[AB-1 -: 10], r_sector, r_key};

    // ------------------------------------------------------------------
    // configuration writes
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_comm_mode   <= MODE_OPEN;
            r_hall_offset <= '0;
            r_cpr         <= 25'd4096;
            r_pole_pairs  <= 6'd4;
            r_cnt_to_ang  <= 32'd4194304;
            r_max_step    <= 16'd2048;
            r_fault_en    <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_COMM_MODE:   r_comm_mode   <= i_cfg_data[2:0];
                REG_HALL_OFFSET: r_hall_offset <= i_cfg_data[15:0];
                REG_CPR:         r_cpr         <= i_cfg_data[24:0];
                REG_POLE_PAIRS:  r_pole_pairs  <= i_cfg_data[5:0];
                REG_CNT_TO_ANG:  r_cnt_to_ang  <= i_cfg_data;
                REG_MAX_STEP:    r_max_step    <= i_cfg_data[15:0];
                REG_FAULT_EN:    r_fault_en    <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // sequencer and tracking state
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_sector      <= BAD_SECTOR;
            r_hall_fault  <= FC_NONE;
            r_started     <= 1'b0;
            r_prev_key    <= '0;
            r_prev2_key   <= '0;
            r_hall_angle  <= '0;
            r_last_edge   <= '0;
            r_last_enc    <= '0;
            r_wrapped     <= '0;
            r_angle_now   <= '0;
            r_aligned     <= 1'b0;
            r_status_hold <= '0;
            r_speed       <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            // a new result loads the output register, a taken one empties it
            if (w_commit) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_state <= S_HALL;
                    end
                end
                S_HALL: begin
                    r_sector   <= w_val;
                    r_last_enc <= r_enc_in;
                    r_state    <= S_MODST;
                    if (w_val == BAD_SECTOR) begin
                        r_hall_fault <= FC_KEY;
                        r_stat       <= HS_ERR;
                        r_spd_go     <= 1'b0;
                    end else if ((r_sector == w_val) || (r_hall_fault != FC_NONE)
                                 || !r_started) begin
                        r_hall_fault <= FC_NONE;
                        r_stat       <= HS_NONE;
                        r_spd_go     <= 1'b0;
                        r_hall_angle <= sect_angle(w_val) + from16(r_hall_offset);
                        if (!r_started) begin
                            r_started   <= 1'b1;
                            r_prev_key  <= r_key;
                            r_prev2_key <= r_key;
                        end
                    end else if ((w_step == 3'd1) || (w_step == 3'd5)) begin
                        // one sector move: half a sector toward the new one
                        r_hall_fault <= FC_NONE;
                        r_stat       <= HS_EDGE;
                        r_dir_fwd    <= (w_step == 3'd1);
                        r_hall_angle <= (w_step == 3'd1) ? r_hall_angle + HALF_SECTOR
                                                         : r_hall_angle - HALF_SECTOR;
                        r_last_edge  <= r_edge;
                        r_prev2_key  <= r_prev_key;
                        r_prev_key   <= r_key;
                        r_t          <= ($signed(w_dt) < $signed(MIN_DT)) ? MIN_DT : w_dt;
                        r_spd_go     <= w_fast;
                        if (!w_fast) begin
                            r_speed <= '0;
                        end
                    end else begin
                        r_hall_fault <= FC_JUMP;
                        r_stat       <= HS_ERR;
                        r_spd_go     <= 1'b0;
                    end
                end
                S_MODST: r_state <= S_MODW;
                S_MODW: begin
                    if (w_div_rsp.done) begin
                        r_enc   <= w_enc_wrap;
                        r_state <= S_E4ST;
                    end
                end
                S_E4ST: r_state <= S_E4W;
                S_E4W: begin
                    if (w_div_rsp.done) begin
                        r_e4h   <= w_div_rsp.quot[24:0];
                        r_state <= r_spd_go ? S_DENM : S_EAH;
                    end
                end
                S_DENM: r_state <= S_SPST;
                S_SPST: r_state <= S_SPW;
                S_SPW: begin
                    if (w_div_rsp.done) begin
                        r_speed <= r_dir_fwd ? $signed(w_div_rsp.quot[25:0])
                                             : -$signed(w_div_rsp.quot[25:0]);
                        r_state <= S_EAH;
                    end
                end
                S_EAH: r_state <= S_EAE;
                S_EAE: begin
                    r_ah    <= w_prod_ang;
                    r_state <= S_MODE;
                end
                S_MODE: begin
                    r_ae    <= w_prod_ang;
                    r_state <= S_EAF;
                end
                S_EAF: begin
                    r_encf    <= n_encf;
                    r_aligned <= n_aligned;
                    r_err     <= n_err;
                    r_fatal   <= n_fatal;
                    r_fcode   <= n_fcode;
                    r_mode_ok <= n_mode_ok;
                    r_state   <= S_LIM;
                end
                S_LIM: begin
                    if (w_commit) begin
                        r_angle_now   <= n_angle_now;
                        if (r_mode_ok) begin
                            r_wrapped <= r_encf;
                        end
                        r_status_hold <= n_status;
                        r_state       <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // mode decisions need both hall and encoder angles; the deviation
    // uses the angles captured in S_EAE and S_MODE
    // (r_ah lands in S_EAE, r_ae in S_MODE, decisions are registered in S_EAF)

    // item capture and result payload
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_key    <= i_in.hall_bits;
            r_enc_in <= i_in.encoder_pos[EB-1:0];
            r_edge   <= i_in.edge_time;
        end
        if (r_state == S_HALL) begin
            r_s <= w_s;
        end
        if (w_commit) begin
            r_o_err    <= r_err;
            r_o_stat   <= r_stat;
            r_o_fcode  <= r_fcode;
            r_o_fatal  <= r_fatal && r_fault_en;
            r_o_comm   <= to16(n_angle_now);
            r_o_hall   <= to16(r_hall_angle);
            r_o_speed  <= r_speed;
            r_o_status <= n_status;
            r_o_hword  <= w_hword;
        end
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.ret_error      = r_o_err;
    assign o_out.hall_status    = r_o_stat;
    assign o_out.fault_code     = r_o_fcode;
    assign o_out.fault_fatal    = r_o_fatal;
    assign o_out.comm_angle     = r_o_comm;
    assign o_out.hall_angle_out = r_o_hall;
    assign o_out.hall_speed     = $signed(r_o_speed);
    assign o_out.status_word    = r_o_status;
    assign o_out.hall_word      = r_o_hword;

    // ------------------------------------------------------------------
    // checks
    // ------------------------------------------------------------------
    `HEC_ASSERT_NXT(a_busy_after_take, i_clk, i_rst_n, w_accept, !i_in.ready,
        "input taken while an item is in flight")
    `HEC_ASSERT_IMP(a_wrap_in_range, i_clk, i_rst_n,
        (r_state == S_MODW) && w_div_rsp.done, w_div_rsp.rem < DIV_DW'(w_cpr_eff),
        "wrapped encoder remainder not below counts per turn")
    `HEC_ASSERT_IMP(a_hall_count_in_range, i_clk, i_rst_n,
        (r_state == S_E4W) && w_div_rsp.done, w_div_rsp.quot < DIV_NW'(w_cpr_eff),
        "hall encoder count not below counts per turn")
    `HEC_ASSERT_IMP(a_align_drop_mode, i_clk, i_rst_n, $fell(r_aligned),
        $past(r_comm_mode) == MODE_ENC_RST,
        "alignment dropped outside encoder with reset mode")

endmodule

@@ test/hall_encoder_commutation_checker.sv @@
// ----------------------------------------------------------------------------
// hall_encoder_commutation_checker
// watches the item channels and register writes, predicts each result of the
// commutation block and compares it field by field
// ----------------------------------------------------------------------------
module hall_encoder_commutation_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    hec_in_if           i_in,
    hec_out_if          i_out,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_data,
    output int          o_pending,
    output int          o_fail_count
);
    import hec_pkg::*;

    localparam longint TICK_HZ     = 200000000;
    localparam int     HALF_SECT   = 5461;
    localparam longint MIN_TICKS   = 2000;
    localparam longint MAX_TICKS   = TICK_HZ / 20;

    typedef struct packed {
        logic        ret_error;
        logic [1:0]  hall_status;
        logic [1:0]  fault_code;
        logic        fault_fatal;
        logic [15:0] comm_angle;
        logic [15:0] hall_angle_out;
        logic [25:0] hall_speed;
        logic [15:0] status_word;
        logic [15:0] hall_word;
    } angle_result_t;

    // hall key to sector map, 7 marks an illegal key
    localparam logic [2:0] KEY_SECTOR [8] = '{3'd7, 3'd0, 3'd2, 3'd1,
                                              3'd4, 3'd5, 3'd3, 3'd7};

    // register copies
    logic [2:0]  mode_r;
    logic [15:0] offset_r;
    logic [24:0] cpr_r;
    logic [5:0]  pp_r;
    logic [31:0] cta_r;
    logic [15:0] step_r;
    logic        fen_r;

    // estimator state
    logic [2:0]  sector_q;
    logic [1:0]  fault_q;
    logic        started_q;
    logic [2:0]  key1_q, key2_q;
    logic [15:0] hangle_q;
    logic [31:0] edge_q, enc_q;
    logic [24:0] wrap_q;
    logic [15:0] comm_q;
    logic        aligned_q;
    logic [15:0] status_q;
    logic [31:0] speed_q;

    angle_result_t expected_q[$];
    int            fails;

    assign o_pending    = expected_q.size();
    assign o_fail_count = fails;

    function automatic logic [15:0] count_angle(input longint unsigned cnt);
        longint unsigned p;
        p = cnt * longint'(cta_r);
        return p[31:16];
    endfunction

    function automatic int circ_diff(input logic [15:0] a, input logic [15:0] b);
        logic [15:0] d;
        d = a - b;
        return int'($signed(d));
    endfunction

    task automatic predict_item(input logic [2:0] key, input logic [31:0] enc_in,
                                input logic [31:0] edge_t);
        angle_result_t r;
        logic [2:0]  hold, val;
        logic [1:0]  excp;
        logic [31:0] du, u;
        longint      delta, e, cpr, pp, dt, t, den, num, mag;
        longint unsigned enc, e4h;
        int          stat, sect_step, d, lim, dir;
        logic        err, fatal, good_mode;
        logic [1:0]  fcode;
        logic [15:0] nudge;

        cpr   = (cpr_r == 0) ? 1 : longint'(cpr_r);
        pp    = (pp_r == 0) ? 1 : longint'(pp_r);
        du    = enc_in - enc_q;
        delta = longint'($signed(du));
        enc_q = enc_in;
        e = (longint'(wrap_q) + delta) % cpr;
        if (e < 0) e += cpr;
        enc = e;

        // hall decode
        hold     = sector_q;
        excp     = fault_q;
        val      = KEY_SECTOR[key];
        sector_q = val;
        stat     = 0;
        if (val == BAD_SECTOR) begin
            fault_q = 2'd1;
            stat    = -1;
        end else begin
            fault_q = 2'd0;
            if (hold == val || excp != 0 || !started_q) begin
                hangle_q = 16'(((longint'(val) << 16) + 3) / 6) + offset_r;
                if (!started_q) begin
                    started_q = 1'b1;
                    key1_q    = key;
                    key2_q    = key;
                end
            end else begin
                sect_step = (hold > 5) ? 3 : (int'(val) + 6 - int'(hold)) % 6;
                if (sect_step == 1) dir = 1;
                else if (sect_step == 5) dir = -1;
                else dir = 0;
                if (dir == 0) begin
                    fault_q = 2'd2;
                    stat    = -1;
                end else begin
                    hangle_q = (dir > 0) ? hangle_q + HALF_SECT : hangle_q - HALF_SECT;
                    u      = edge_t - edge_q;
                    dt     = longint'($signed(u));
                    edge_q = edge_t;
                    if (dt > MAX_TICKS || key == key2_q) begin
                        speed_q = '0;
                    end else begin
                        t   = (dt < MIN_TICKS) ? MIN_TICKS : dt;
                        den = 6 * pp * t;
                        num = 1024 * TICK_HZ;
                        mag = (2 * num + den) / (2 * den);
                        speed_q = (dir > 0) ? 32'(mag) : 32'(-mag);
                    end
                    key2_q = key1_q;
                    key1_q = key;
                    stat   = 1;
                end
            end
        end

        e4h   = (longint'(hangle_q) * cpr) / (pp << 16);
        fcode = fault_q;
        err   = 1'b0;
        fatal = 1'b0;
        good_mode = 1'b1;

        case (mode_r)
            MODE_OPEN: ;
            MODE_HALL: begin
                if (fault_q == 0) enc = e4h;
                else begin fatal = 1'b1; err = 1'b1; end
            end
            MODE_ENC: begin
                if (!aligned_q) begin
                    if (fault_q == 0) begin
                        if (stat == 1) begin enc = e4h; aligned_q = 1'b1; end
                    end else begin
                        fatal = 1'b1; err = 1'b1;
                    end
                end else begin
                    d = circ_diff(count_angle(e4h), count_angle(enc));
                    if (d < 0) d = -d;
                    if (longint'(d) * 100 > (longint'(12) << 16)) begin
                        fcode = FC_DEV; fatal = 1'b1;
                    end
                end
            end
            MODE_ENC_RST: begin
                if (fault_q == 0) begin
                    if (stat == 1) begin aligned_q = 1'b1; enc = e4h; end
                    else begin
                        d = circ_diff(count_angle(e4h), count_angle(enc));
                        if (d < 0) d = -d;
                        if (longint'(d) * 8 > (longint'(1) << 16)) aligned_q = 1'b0;
                        if (!aligned_q) enc = e4h;
                    end
                end else if (!aligned_q) begin
                    fatal = 1'b1; err = 1'b1;
                end
            end
            default: begin
                good_mode = 1'b0;
                err = 1'b1;
            end
        endcase

        if (good_mode) begin
            if (mode_r != MODE_OPEN) begin
                d   = circ_diff(count_angle(enc), comm_q);
                lim = int'(step_r);
                if (d > lim) d = lim;
                if (d < -lim) d = -lim;
                nudge  = 16'(d);
                comm_q = comm_q + nudge;
            end
            wrap_q   = enc[24:0];
            status_q = {stat == 1, fault_q != 0, err, aligned_q, 2'b00, comm_q[15:6]};
        end

        r.ret_error      = err;
        r.hall_status    = (stat == 1) ? HS_EDGE : ((stat < 0) ? HS_ERR : HS_NONE);
        r.fault_code     = fcode;
        r.fault_fatal    = fatal && fen_r;
        r.comm_angle     = comm_q;
        r.hall_angle_out = hangle_q;
        r.hall_speed     = speed_q[25:0];
        r.status_word    = status_q;
        r.hall_word      = {hangle_q[15:6], sector_q, key};
        expected_q.push_back(r);
    endtask

    always @(posedge i_clk) begin
        angle_result_t got, want;
        if (!i_rst_n) begin
            mode_r = MODE_OPEN; offset_r = '0; cpr_r = 25'd4096; pp_r = 6'd4;
            cta_r = 32'd4194304; step_r = 16'd2048; fen_r = 1'b0;
            sector_q = BAD_SECTOR; fault_q = '0; started_q = 1'b0;
            key1_q = '0; key2_q = '0; hangle_q = '0; edge_q = '0; enc_q = '0;
            wrap_q = '0; comm_q = '0; aligned_q = 1'b0; status_q = '0;
            speed_q = '0;
            expected_q.delete();
            fails = 0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_COMM_MODE:   mode_r   = i_cfg_data[2:0];
                    REG_HALL_OFFSET: offset_r = i_cfg_data[15:0];
                    REG_CPR:         cpr_r    = i_cfg_data[24:0];
                    REG_POLE_PAIRS:  pp_r     = i_cfg_data[5:0];
                    REG_CNT_TO_ANG:  cta_r    = i_cfg_data;
                    REG_MAX_STEP:    step_r   = i_cfg_data[15:0];
                    REG_FAULT_EN:    fen_r    = i_cfg_data[0];
                    default: ;
                endcase
            end
            // results first: a result never belongs to an item taken on the same edge
            if (i_out.valid && i_out.ready) begin
                got = {i_out.ret_error, i_out.hall_status, i_out.fault_code,
                       i_out.fault_fatal, i_out.comm_angle, i_out.hall_angle_out,
                       i_out.hall_speed, i_out.status_word, i_out.hall_word};
                if (expected_q.size() == 0) begin
                    fails++;
                    if (fails <= 10) $display("unexpected result item %h", got);
                end else begin
                    want = expected_q.pop_front();
                    if (got !== want) begin
                        fails++;
                        if (fails <= 10)
                            $display("mismatch: err %b/%b hs %0d/%0d fc %0d/%0d fat %b/%b ",
                                     want.ret_error, got.ret_error, want.hall_status,
                                     got.hall_status, want.fault_code, got.fault_code,
                                     want.fault_fatal, got.fault_fatal,
                                     "ca %h/%h ha %h/%h sp %h/%h sw %h/%h hw %h/%h",
                                     want.comm_angle, got.comm_angle, want.hall_angle_out,
                                     got.hall_angle_out, want.hall_speed, got.hall_speed,
                                     want.status_word, got.status_word, want.hall_word,
                                     got.hall_word);
                    end
                end
            end
            if (i_in.valid && i_in.ready)
                predict_item(i_in.hall_bits, i_in.encoder_pos, i_in.edge_time);
        end
    end
endmodule

@@ test/hall_encoder_commutation_top_tb.sv @@
// ----------------------------------------------------------------------------
// hall_encoder_commutation_top_tb
// drives hall, encoder and edge time items through the commutation block in
// phases of register settings and idle patterns; a checker beside the block
// predicts and compares every result
// ----------------------------------------------------------------------------
module hall_encoder_commutation_top_tb;
    import hec_pkg::*;

    logic        i_clk;
    logic        i_rst_n;
    logic        cfg_we;
    logic [2:0]  cfg_idx;
    logic [31:0] cfg_data;
    int          pending;
    int          fail_count;

    // per phase idle odds, in percent
    int send_idle_pct;
    int recv_stall_pct;

    // long receiver hold-off request and its cycle counter
    logic hold_req;
    logic hold_seen;
    int   hold_left;

    // motion model for well-formed hall sequences
    int          sector_now;
    int          spin_dir;
    logic [31:0] enc_now;
    logic [31:0] edge_now;

    localparam logic [2:0] SECTOR_KEY [6] = '{3'd1, 3'd3, 3'd2, 3'd6, 3'd4, 3'd5};

    hec_in_if  in_if ();
    hec_out_if out_if ();

    hall_encoder_commutation_top dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_if.sink),
        .o_out      (out_if.source),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    hall_encoder_commutation_checker chk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (in_if),
        .i_out        (out_if),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_data   (cfg_data),
        .o_pending    (pending),
        .o_fail_count (fail_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // result side: random stalls, plus one long hold-off when asked
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
            hold_seen    <= 1'b0;
            hold_left    <= 0;
        end else if (hold_req && !hold_seen) begin
            hold_seen    <= 1'b1;
            hold_left    <= 3000;
            out_if.ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left    <= hold_left - 1;
            out_if.ready <= 1'b0;
        end else begin
            out_if.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // one register write, enable dropped on the following edge
    task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        @(posedge i_clk);
        cfg_we   <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic load_regs(input logic [2:0] mode, input logic [15:0] offset,
                             input logic [24:0] cpr, input logic [5:0] pp,
                             input logic [31:0] cta, input logic [15:0] step,
                             input logic fen);
        write_reg(REG_COMM_MODE, 32'(mode));
        write_reg(REG_HALL_OFFSET, 32'(offset));
        write_reg(REG_CPR, 32'(cpr));
        write_reg(REG_POLE_PAIRS, 32'(pp));
        write_reg(REG_CNT_TO_ANG, cta);
        write_reg(REG_MAX_STEP, 32'(step));
        write_reg(REG_FAULT_EN, 32'(fen));
    endtask

    // offer one item, idle at random before it, return on acceptance
    task automatic send_item(input logic [2:0] key, input logic [31:0] enc,
                             input logic [31:0] edge_t);
        while ($urandom_range(99) < send_idle_pct) begin
            in_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_if.valid       <= 1'b1;
        in_if.hall_bits   <= key;
        in_if.encoder_pos <= enc;
        in_if.edge_time   <= edge_t;
        do @(posedge i_clk); while (!(in_if.valid && in_if.ready));
    endtask

    // drop valid and wait for every result, then let the block settle
    task automatic drain;
        in_if.valid <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
    endtask

    // next item of a mostly well-formed rotation with some noise
    task automatic random_item;
        int pick;
        int gap_kind;
        logic [2:0] key;
        pick = $urandom_range(99);
        if ($urandom_range(99) < 8) spin_dir = -spin_dir;
        if (pick < 72) begin
            sector_now = (sector_now + spin_dir + 6) % 6;
            enc_now    = enc_now + 32'(spin_dir * 171) + 32'($urandom_range(20)) - 32'd10;
        end else if (pick < 84) begin
            enc_now = enc_now + 32'($urandom_range(40)) - 32'd20;
        end else if (pick < 90) begin
            sector_now = (sector_now + 2 + $urandom_range(2)) % 6;
        end else if (pick < 95) begin
            enc_now = $urandom;
        end
        key = (pick >= 84 && pick < 90) ? SECTOR_KEY[sector_now]
            : (pick >= 95) ? 3'($urandom_range(7))
            : SECTOR_KEY[sector_now];
        if (pick >= 90 && pick < 95) key = $urandom_range(1) ? 3'd0 : 3'd7;
        gap_kind = $urandom_range(99);
        if (gap_kind < 10)      edge_now = edge_now + 32'($urandom_range(2500));
        else if (gap_kind < 80) edge_now = edge_now + 32'($urandom_range(3_000_000, 2000));
        else if (gap_kind < 90) edge_now = edge_now + 32'($urandom_range(20_000_000, 9_000_000));
        else                    edge_now = $urandom;
        send_item(key, enc_now, edge_now);
    endtask

    task automatic random_phase(input int n, input int idle_kind);
        case (idle_kind % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 69; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 69; end
            default: begin send_idle_pct = 26; recv_stall_pct = 26; end
        endcase
        repeat (n) random_item();
        drain();
    endtask

    initial begin
        i_rst_n           = 1'b0;
        cfg_we            = 1'b0;
        cfg_idx           = '0;
        cfg_data          = '0;
        in_if.valid       = 1'b0;
        in_if.hall_bits   = '0;
        in_if.encoder_pos = '0;
        in_if.edge_time   = '0;
        hold_req          = 1'b0;
        send_idle_pct     = 0;
        recv_stall_pct    = 0;
        sector_now        = 0;
        spin_dir          = 1;
        enc_now           = '0;
        edge_now          = '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: every key, illegal keys, jumps, reversal, field extremes
        load_regs(MODE_HALL, 16'd0, 25'd4096, 6'd4, 32'd4194304, 16'd2048, 1'b1);
        send_item(3'd0, 32'h0000_0000, 32'h0000_0000);
        send_item(3'd1, 32'h7fff_ffff, 32'h0000_0000);
        send_item(3'd1, 32'h8000_0000, 32'hffff_ffff);
        send_item(3'd3, 32'hffff_ffff, 32'h0000_0100);
        send_item(3'd2, 32'h0000_0100, 32'h0001_0000);
        send_item(3'd6, 32'h0000_0200, 32'h0100_0000);
        send_item(3'd4, 32'h0000_0300, 32'h0110_0000);
        send_item(3'd5, 32'h0000_0400, 32'h0120_0000);
        send_item(3'd4, 32'h0000_0300, 32'h0130_0000);
        send_item(3'd5, 32'h0000_0400, 32'h0130_0010);
        send_item(3'd7, 32'h0000_0400, 32'h0140_0000);
        send_item(3'd5, 32'h0000_0400, 32'h0150_0000);
        send_item(3'd3, 32'h0000_0400, 32'h0160_0000);
        send_item(3'd1, 32'h0000_0400, 32'h0170_0000);
        send_item(3'd5, 32'h0000_0400, 32'h8000_0000);
        send_item(3'd4, 32'h5555_5555, 32'haaaa_aaaa);
        send_item(3'd6, 32'haaaa_aaaa, 32'h5555_5555);
        send_item(3'd2, 32'h0000_0000, 32'h5555_6000);
        drain();

        // extreme settings, then a spread of modes with every idle pattern
        load_regs(MODE_ENC_RST, 16'hffff, 25'd16777216, 6'd32, 32'hffff_ffff,
                  16'd32768, 1'b1);
        random_phase(60, 0);
        load_regs(MODE_OPEN, 16'd12345, 25'd1, 6'd1, 32'd0, 16'd0, 1'b0);
        random_phase(60, 1);
        load_regs(MODE_ENC, 16'd0, 25'd4096, 6'd4, 32'd4194304, 16'd2048, 1'b1);
        random_phase(100, 2);
        load_regs(MODE_ENC_RST, 16'd8000, 25'd4096, 6'd4, 32'd4194304, 16'd1000, 1'b1);
        random_phase(100, 3);

        // long result hold-off while items keep coming, so the input backs up
        load_regs(MODE_HALL, 16'd300, 25'd4096, 6'd4, 32'd4194304, 16'd32768, 1'b0);
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_req <= 1'b1;
        repeat (40) random_item();
        drain();

        load_regs(3'd5, 16'd100, 25'd2000, 6'd3, 32'd3000000, 16'd500, 1'b1);
        random_phase(40, 1);
        load_regs(3'd7, 16'd100, 25'd2000, 6'd3, 32'd3000000, 16'd500, 1'b0);
        random_phase(30, 2);
        load_regs(3'd4, 16'd0, 25'd4096, 6'd4, 32'd4194304, 16'd2048, 1'b1);
        random_phase(30, 0);
        load_regs(3'd6, 16'd0, 25'd4096, 6'd4, 32'd4194304, 16'd2048, 1'b1);
        random_phase(20, 3);
        load_regs(MODE_ENC, 16'd40000, 25'd1000, 6'd7, 32'd613566757, 16'd0, 1'b1);
        random_phase(100, 0);
        load_regs(MODE_ENC, 16'($urandom), 25'($urandom_range(16777216, 1)),
                  6'($urandom_range(32, 1)), $urandom, 16'($urandom_range(32768)), 1'b1);
        random_phase(80, 1);
        load_regs(MODE_ENC_RST, 16'($urandom), 25'($urandom_range(5000, 1)),
                  6'($urandom_range(32, 1)), $urandom, 16'($urandom_range(32768)), 1'b0);
        random_phase(100, 3);
        load_regs(MODE_HALL, 16'($urandom), 25'($urandom_range(16777216, 1)),
                  6'($urandom_range(32, 1)), $urandom, 16'($urandom_range(32768)), 1'b1);
        random_phase(100, 2);

        if (fail_count == 0) begin
            $display("hall_encoder_commutation_top_tb: done, clean");
        end else begin
            $display("hall_encoder_commutation_top_tb: done, errors");
        end
        $finish;
    end

    // run limit, far beyond the slowest correct run
    initial begin
        #50000000;
        $display("hall_encoder_commutation_top_tb: done, errors");
        $finish;
    end
endmodule

@@ sim.f @@
+incdir+sv
sv/hec_pkg.sv
sv/hec_if.sv
sv/hec_div.sv
sv/hall_encoder_commutation_top.sv
test/hall_encoder_commutation_checker.sv
test/hall_encoder_commutation_top_tb.sv
